>>> src/bad_sector_table_checker_core_assert.svh
// Assertion macros shared by the bad-sector table checker RTL.
`ifndef BAD_SECTOR_TABLE_CHECKER_CORE_ASSERT_SVH
`define BAD_SECTOR_TABLE_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BSTC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BSTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/bstc_pkg.sv
// Types and constants of the bad-sector table checker.
`default_nettype none

package bstc_pkg;

   localparam int MAX_ENTRIES = 126;
   localparam int IDX_W       = $clog2(MAX_ENTRIES + 1);
   localparam int COUNT_W     = 7;
   localparam int ERR_W       = 9;

   localparam logic [15:0]      TABLE_MAGIC = 16'h4321;
   localparam logic [15:0]      END_WORD    = 16'hffff;
   localparam logic [ERR_W-1:0] ERR_MAX     = 9'd511;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_ENTRY  = 1'b1;

   localparam logic [1:0] ST_HEADER  = 2'd0;
   localparam logic [1:0] ST_ENTRY   = 2'd1;
   localparam logic [1:0] ST_END     = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   localparam logic [1:0] CSR_CYLINDERS = 2'd0;
   localparam logic [1:0] CSR_TRACKS    = 2'd1;
   localparam logic [1:0] CSR_SECTORS   = 2'd2;

   localparam logic [15:0] CYLINDERS_RESET = 16'd1024;
   localparam logic [8:0]  TRACKS_RESET    = 9'd16;
   localparam logic [8:0]  SECTORS_RESET   = 9'd63;

   typedef struct packed {
      logic        opcode;
      logic [15:0] cylinder;
      logic [15:0] track_sector;
      logic [15:0] header_flag;
      logic [15:0] header_zero_word;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         item_status;
      logic               out_of_range;
      logic               out_of_order;
      logic               duplicate;
      logic               bad_flag;
      logic               bad_zero_word;
      logic [31:0]        sector_number;
      logic [COUNT_W-1:0] entry_count;
      logic [ERR_W-1:0]   error_count;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] cylinders_in_use;
      logic [8:0]  tracks_per_cylinder;
      logic [8:0]  sectors_per_track;
   } geometry_type;

   // One pass through the shared multiply-add unit: result = a * b + c.
   typedef struct packed {
      logic        en;
      logic [31:0] a;
      logic [8:0]  b;
      logic [7:0]  c;
   } mac_cmd_type;

endpackage

`default_nettype wire

>>> src/bstc_if.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface bstc_req_if import bstc_pkg::*;;
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bstc_rsp_if import bstc_pkg::*;;
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/bstc_csr.sv
// Disk geometry registers written through the plain write port.
`default_nettype none

module bstc_csr import bstc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wr_data,
   output geometry_type      geometry
);

   geometry_type geo_ff;
   geometry_type geo_in;

   always_comb begin
      geo_in = geo_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CYLINDERS: geo_in.cylinders_in_use    = csr_wr_data;
            CSR_TRACKS:    geo_in.tracks_per_cylinder = csr_wr_data[8:0];
            CSR_SECTORS:   geo_in.sectors_per_track   = csr_wr_data[8:0];
            default:       geo_in = geo_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff.cylinders_in_use    <= CYLINDERS_RESET;
         geo_ff.tracks_per_cylinder <= TRACKS_RESET;
         geo_ff.sectors_per_track   <= SECTORS_RESET;
      end else begin
         geo_ff <= geo_in;
      end
   end

   assign geometry = geo_ff;

endmodule

`default_nettype wire

>>> src/bstc_mac.sv
// Shared multiply-add unit with a registered 32-bit result.
`default_nettype none

module bstc_mac import bstc_pkg::*; (
   input  wire logic         clock,
   input  mac_cmd_type       cmd,
   output logic [31:0]       result
);

   logic [40:0] product;
   logic [40:0] sum;
   logic [31:0] result_ff;
   logic [31:0] result_in;

   always_comb begin
      product   = 41'(cmd.a) * 41'(cmd.b);
      sum       = product + 41'(cmd.c);
      // The linear sector number wraps modulo 2^32.
      result_in = sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

>>> src/bad_sector_table_checker_core.sv
// Top level of the bad-sector table checker: sequencer, table state and result register.
`default_nettype none
`include "bad_sector_table_checker_core_assert.svh"

// Checks a bad-sector table one word at a time. A table entry goes from acceptance to a
// valid result through the accept cycle, two passes through the single shared
// multiply-add unit ((cylinder * tracks + track) and then (* sectors + sector)), and a
// finish cycle that runs the range, order and duplicate checks and updates the counts.
// Header, end-marker and ignored words skip the multiply-add unit.
// The block accepts one word at a time; the result sits in an output register, so a
// new word is taken while an earlier result still waits, and the finish cycle only
// stretches when that register is still full.
module bad_sector_table_checker_core import bstc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   bstc_req_if.sink          req_ch,
   bstc_rsp_if.source        rsp_ch,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL1 = 2'd1;
   localparam logic [1:0] S_MUL2 = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   geometry_type geometry;
   mac_cmd_type  mac_cmd;
   logic [31:0]  mac_result;

   logic [1:0]       state_ff, state_in;
   req_word_type     item_ff, item_in;
   logic [31:0]      prev_ff, prev_in;
   logic [IDX_W-1:0] entry_index_ff, entry_index_in;
   logic             finished_ff, finished_in;
   logic             warned_ff, warned_in;
   logic [ERR_W-1:0] errors_ff, errors_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             accept;
   logic             table_closed;
   logic             req_is_entry;
   logic             item_is_end;
   logic             out_free;
   logic             fin;
   logic [7:0]       trk;
   logic [7:0]       sec;
   logic [1:0]       err_inc;
   logic [ERR_W:0]   err_sum;

   bstc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .geometry    (geometry)
   );

   bstc_mac u_mac (
      .clock  (clock),
      .cmd    (mac_cmd),
      .result (mac_result)
   );

   always_comb begin
      req_ch.ready = (state_ff == S_IDLE);
      accept       = req_ch.valid && req_ch.ready;
      table_closed = finished_ff || (entry_index_ff >= IDX_W'(MAX_ENTRIES));
      req_is_entry = (req_ch.payload.opcode == OP_ENTRY) && !table_closed &&
                     !((req_ch.payload.cylinder == END_WORD) &&
                       (req_ch.payload.track_sector == END_WORD));
      trk          = item_ff.track_sector[15:8];
      sec          = item_ff.track_sector[7:0];
      item_is_end  = (item_ff.cylinder == END_WORD) && (item_ff.track_sector == END_WORD);
      out_free     = !rsp_valid_ff || rsp_ch.ready;
      fin          = (state_ff == S_FIN) && out_free;

      mac_cmd.en = (state_ff == S_MUL1) || (state_ff == S_MUL2);
      if (state_ff == S_MUL1) begin
         mac_cmd.a = {16'd0, item_ff.cylinder};
         mac_cmd.b = geometry.tracks_per_cylinder;
         mac_cmd.c = trk;
      end else begin
         mac_cmd.a = mac_result;
         mac_cmd.b = geometry.sectors_per_track;
         mac_cmd.c = sec;
      end

      item_in = accept ? req_ch.payload : item_ff;

      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = req_is_entry ? S_MUL1 : S_FIN;
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_FIN;
         S_FIN: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result word and table state update of the finish cycle.
   always_comb begin
      prev_in        = prev_ff;
      entry_index_in = entry_index_ff;
      finished_in    = finished_ff;
      warned_in      = warned_ff;
      errors_in      = errors_ff;
      rsp_word_in    = '0;
      err_inc        = '0;
      err_sum        = '0;

      if (item_ff.opcode == OP_HEADER) begin
         rsp_word_in.item_status   = ST_HEADER;
         rsp_word_in.bad_flag      = (item_ff.header_flag != TABLE_MAGIC);
         rsp_word_in.bad_zero_word = (item_ff.header_zero_word != 16'd0);
         prev_in        = '0;
         entry_index_in = '0;
         finished_in    = 1'b0;
         warned_in      = 1'b0;
         errors_in      = ERR_W'(rsp_word_in.bad_flag) + ERR_W'(rsp_word_in.bad_zero_word);
      end else if (table_closed) begin
         rsp_word_in.item_status = ST_IGNORED;
      end else if (item_is_end) begin
         rsp_word_in.item_status = ST_END;
         finished_in = 1'b1;
      end else begin
         rsp_word_in.item_status   = ST_ENTRY;
         rsp_word_in.out_of_range  = (item_ff.cylinder >= geometry.cylinders_in_use) ||
                                     ({1'b0, trk} >= geometry.tracks_per_cylinder) ||
                                     ({1'b0, sec} >= geometry.sectors_per_track);
         rsp_word_in.sector_number = mac_result;
         rsp_word_in.out_of_order  = (entry_index_ff != '0) && (mac_result < prev_ff) &&
                                     !warned_ff;
         rsp_word_in.duplicate     = (entry_index_ff != '0) && (mac_result == prev_ff);
         err_inc = {1'b0, rsp_word_in.out_of_range} + {1'b0, rsp_word_in.out_of_order} +
                   {1'b0, rsp_word_in.duplicate};
         err_sum = {1'b0, errors_ff} + (ERR_W + 1)'(err_inc);
         // Saturating count: several errors of one entry stop at the ceiling.
         errors_in      = (err_sum > {1'b0, ERR_MAX}) ? ERR_MAX : err_sum[ERR_W-1:0];
         warned_in      = warned_ff || rsp_word_in.out_of_order;
         prev_in        = mac_result;
         entry_index_in = entry_index_ff + IDX_W'(1);
      end
      rsp_word_in.entry_count = COUNT_W'(entry_index_in);
      rsp_word_in.error_count = errors_in;

      if (fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         prev_ff        <= '0;
         entry_index_ff <= '0;
         finished_ff    <= 1'b0;
         warned_ff      <= 1'b0;
         errors_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fin) begin
            prev_ff        <= prev_in;
            entry_index_ff <= entry_index_in;
            finished_ff    <= finished_in;
            warned_ff      <= warned_in;
            errors_ff      <= errors_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (fin) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_word_ff;

   `BSTC_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != S_IDLE,
                     "accepted word did not start work")
   `BSTC_ASSERT_NOW(a_index_bounded, 1'b1, entry_index_ff <= IDX_W'(MAX_ENTRIES),
                    "entry index beyond table size")
   `BSTC_ASSERT_NEXT(a_closed_ignored,
                     fin && (item_ff.opcode == OP_ENTRY) && finished_ff,
                     rsp_word_ff.item_status == ST_IGNORED,
                     "entry after end marker not ignored")
   `BSTC_ASSERT_NOW(a_header_errors,
                    rsp_valid_ff && (rsp_word_ff.item_status == ST_HEADER),
                    rsp_word_ff.error_count <= ERR_W'(2),
                    "header error count above two")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the bad-sector table checker core.
module tb;
   import bstc_pkg::*;

   // Index 3 of the register port selects no register; writes there are dropped.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wr_data;

   bstc_req_if req_ch ();
   bstc_rsp_if rsp_ch ();

   bad_sector_table_checker_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Geometry and table state as the block should hold them.
   logic [15:0]      geo_cylinders = CYLINDERS_RESET;
   logic [8:0]       geo_tracks    = TRACKS_RESET;
   logic [8:0]       geo_sectors   = SECTORS_RESET;
   logic [31:0]      last_sector   = '0;
   logic [IDX_W-1:0] entries_taken = '0;
   bit               table_closed  = 1'b0;
   bit               order_flagged = 1'b0;
   logic [ERR_W-1:0] table_errors  = '0;

   req_word_type table_words_to_send[$];
   rsp_word_type expected_reports[$];

   int send_wait       = 0;
   int recv_wait       = 0;
   bit send_calm       = 1'b0;
   bit recv_calm       = 1'b0;
   bit hold_results    = 1'b0;
   int words_planned   = 0;
   int words_accepted  = 0;
   int results_checked = 0;
   int tables_sent     = 0;
   int settings_run    = 0;
   int mismatch_count  = 0;

   function automatic void bump_errors();
      if (table_errors < ERR_MAX) table_errors++;
   endfunction

   // Applies one table word to the table state and returns the report it should produce.
   function automatic rsp_word_type check_table_word(input req_word_type w);
      rsp_word_type r;
      logic [7:0]   trk;
      logic [7:0]   sec;
      logic [31:0]  lin;
      r = '0;
      trk = w.track_sector[15:8];
      sec = w.track_sector[7:0];
      if (w.opcode == OP_HEADER) begin
         r.item_status   = ST_HEADER;
         r.bad_flag      = (w.header_flag != TABLE_MAGIC);
         r.bad_zero_word = (w.header_zero_word != 16'd0);
         last_sector     = '0;
         entries_taken   = '0;
         table_closed    = 1'b0;
         order_flagged   = 1'b0;
         table_errors    = ERR_W'(r.bad_flag) + ERR_W'(r.bad_zero_word);
      end else if (table_closed || entries_taken >= MAX_ENTRIES) begin
         r.item_status = ST_IGNORED;
      end else if (w.cylinder == END_WORD && w.track_sector == END_WORD) begin
         r.item_status = ST_END;
         table_closed  = 1'b1;
      end else begin
         r.item_status = ST_ENTRY;
         if (w.cylinder >= geo_cylinders || {1'b0, trk} >= geo_tracks ||
             {1'b0, sec} >= geo_sectors) begin
            r.out_of_range = 1'b1;
            bump_errors();
         end
         // Both steps wrap at 32 bits, as the hardware does.
         lin = 32'(w.cylinder) * 32'(geo_tracks) + 32'(trk);
         lin = lin * 32'(geo_sectors) + 32'(sec);
         r.sector_number = lin;
         if (entries_taken != 0 && lin < last_sector && !order_flagged) begin
            r.out_of_order = 1'b1;
            order_flagged  = 1'b1;
            bump_errors();
         end
         if (entries_taken != 0 && lin == last_sector) begin
            r.duplicate = 1'b1;
            bump_errors();
         end
         last_sector = lin;
         entries_taken++;
      end
      r.entry_count = COUNT_W'(entries_taken);
      r.error_count = table_errors;
      return r;
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic string show_report(input rsp_word_type r);
      return $sformatf("st=%0d rng=%0b ord=%0b dup=%0b flag=%0b zero=%0b sn=%h cnt=%0d err=%0d",
                       r.item_status, r.out_of_range, r.out_of_order, r.duplicate, r.bad_flag,
                       r.bad_zero_word, r.sector_number, r.entry_count, r.error_count);
   endfunction

   task automatic compare_report(input rsp_word_type got);
      rsp_word_type want;
      string        diff;
      results_checked++;
      if (expected_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: result word with nothing expected: %s", $time, show_report(got));
      end else begin
         want = expected_reports.pop_front();
         diff = "";
         if (got.item_status !== want.item_status)     diff = {diff, " item_status"};
         if (got.out_of_range !== want.out_of_range)   diff = {diff, " out_of_range"};
         if (got.out_of_order !== want.out_of_order)   diff = {diff, " out_of_order"};
         if (got.duplicate !== want.duplicate)         diff = {diff, " duplicate"};
         if (got.bad_flag !== want.bad_flag)           diff = {diff, " bad_flag"};
         if (got.bad_zero_word !== want.bad_zero_word) diff = {diff, " bad_zero_word"};
         if (got.sector_number !== want.sector_number) diff = {diff, " sector_number"};
         if (got.entry_count !== want.entry_count)     diff = {diff, " entry_count"};
         if (got.error_count !== want.error_count)     diff = {diff, " error_count"};
         if (diff != "") begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: mismatch in%s\n   expected %s\n   actual   %s",
                        $time, diff, show_report(want), show_report(got));
         end
      end
   endtask

   // Request side: offer the oldest pending word, with random gaps after each accept.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_reports.push_back(check_table_word(table_words_to_send.pop_front()));
            words_accepted++;
            send_wait = pick_gap(send_calm);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_ch.valid <= 1'b0;
            end else if (table_words_to_send.size() > 0) begin
               req_ch.valid   <= 1'b1;
               req_ch.payload <= table_words_to_send[0];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response side: check each accepted word, then stall for a random time.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            compare_report(rsp_ch.payload);
            recv_wait = pick_gap(recv_calm);
         end
         if (hold_results || recv_wait > 0) begin
            if (!hold_results) recv_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic req_word_type entry_word(input logic [15:0] cyl, input logic [15:0] ts);
      req_word_type w;
      w.opcode           = OP_ENTRY;
      w.cylinder         = cyl;
      w.track_sector     = ts;
      w.header_flag      = 16'($urandom);
      w.header_zero_word = 16'($urandom);
      return w;
   endfunction

   function automatic req_word_type header_word(input logic [15:0] flag,
                                                input logic [15:0] zero);
      req_word_type w;
      w.opcode           = OP_HEADER;
      w.cylinder         = 16'($urandom);
      w.track_sector     = 16'($urandom);
      w.header_flag      = flag;
      w.header_zero_word = zero;
      return w;
   endfunction

   task automatic offer(input req_word_type w);
      table_words_to_send.push_back(w);
      words_planned++;
   endtask

   // A header, then entries in rising order with occasional faults, an optional end
   // marker and a few trailing words, which the block ignores only once the table is closed.
   task automatic queue_table(input int n_entries, input bit add_end, input int n_after);
      longint      span;
      longint      pos;
      longint      lin;
      longint      prev_lin;
      longint      step_max;
      longint      eff_t;
      longint      eff_s;
      int          pick;
      logic [15:0] cyl;
      logic [7:0]  trk;
      logic [7:0]  sec;
      pick = $urandom_range(0, 9);
      if (pick < 7)       offer(header_word(TABLE_MAGIC, 16'd0));
      else if (pick == 7) offer(header_word(16'($urandom), 16'd0));
      else if (pick == 8) offer(header_word(TABLE_MAGIC, 16'($urandom_range(1, 65535))));
      else                offer(header_word(16'($urandom), 16'($urandom)));
      tables_sent++;
      // The track and sector fields are 8 bits, so only 256 of each can be named.
      eff_t = (geo_tracks > 256) ? 256 : geo_tracks;
      eff_s = (geo_sectors > 256) ? 256 : geo_sectors;
      span = longint'(geo_cylinders) * eff_t * eff_s;
      step_max = span / (n_entries + 1);
      if (step_max < 1) step_max = 1;
      if (step_max > 64'h4000_0000) step_max = 64'h4000_0000;
      pos = $urandom_range(0, int'(step_max) - 1);
      prev_lin = pos;
      for (int i = 0; i < n_entries; i++) begin
         pick = $urandom_range(0, 99);
         if (span == 0 || pick < 4) begin
            offer(entry_word(16'($urandom), 16'($urandom)));
         end else begin
            if (pick < 7) begin
               lin = prev_lin / 2;
            end else if (pick < 10) begin
               lin = prev_lin;
            end else begin
               lin = pos;
               pos += $urandom_range(1, int'(step_max));
               if (pos >= span) pos = span - 1;
            end
            prev_lin = lin;
            sec = 8'(lin % eff_s);
            lin = lin / eff_s;
            trk = 8'(lin % eff_t);
            cyl = 16'(lin / eff_t);
            offer(entry_word(cyl, {trk, sec}));
         end
      end
      if (add_end) offer(entry_word(END_WORD, END_WORD));
      for (int i = 0; i < n_after; i++) begin
         if ($urandom_range(0, 3) == 0) offer(entry_word(END_WORD, END_WORD));
         else offer(entry_word(16'($urandom), 16'($urandom)));
      end
   endtask

   task automatic queue_random_words(input int budget);
      int start;
      int pick;
      int n;
      start = words_planned;
      while (words_planned - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 1) == 0) offer(header_word(16'($urandom), 16'($urandom)));
               else offer(entry_word(16'($urandom), 16'($urandom)));
            end
         end else begin
            n = (pick < 13) ? $urandom_range(120, 135) : $urandom_range(1, 40);
            queue_table(n, $urandom_range(0, 3) != 0, $urandom_range(0, 3));
         end
      end
   endtask

   task automatic wait_drained();
      while (table_words_to_send.size() != 0 || expected_reports.size() != 0 || req_ch.valid)
         @(negedge clock);
   endtask

   task automatic write_geometry_reg(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_CYLINDERS: geo_cylinders = data;
         CSR_TRACKS:    geo_tracks    = data[8:0];
         CSR_SECTORS:   geo_sectors   = data[8:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until all results are in, so the block is idle during the writes.
   task automatic run_phase(input logic [15:0] cyl, input logic [15:0] trk,
                            input logic [15:0] sec, input bit calm, input int budget);
      wait_drained();
      write_geometry_reg(CSR_CYLINDERS, cyl);
      write_geometry_reg(CSR_TRACKS, trk);
      write_geometry_reg(CSR_SECTORS, sec);
      write_geometry_reg(CSR_UNUSED, 16'($urandom));
      settings_run++;
      @(negedge clock);
      send_calm = calm;
      recv_calm = calm;
      queue_random_words(budget);
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset geometry of 1024 x 16 x 63.
      settings_run++;
      offer(entry_word(16'd5, 16'h0203));      // entry before any header
      offer(entry_word(16'd0, 16'h0000));      // lower than the one before
      offer(header_word(16'h1234, 16'h0000));
      offer(header_word(TABLE_MAGIC, 16'hffff));
      offer(header_word(16'hbcde, 16'h0001));
      offer(header_word(TABLE_MAGIC, 16'h0000));
      offer(entry_word(16'd0, 16'h0000));
      offer(entry_word(16'd0, 16'h0000));
      offer(entry_word(16'd1023, 16'h0f3e));
      offer(entry_word(16'd1024, 16'h0000));
      offer(entry_word(16'd1, 16'h1000));
      offer(entry_word(16'd2, 16'h003f));
      offer(entry_word(16'd0, 16'h0005));
      offer(entry_word(16'd0, 16'h0001));      // a further drop in order is not flagged
      offer(entry_word(16'hffff, 16'h0102));
      offer(entry_word(16'h0003, 16'hffff));
      offer(entry_word(END_WORD, END_WORD));
      offer(entry_word(16'd0, 16'h0001));
      offer(entry_word(END_WORD, END_WORD));
      offer(header_word(TABLE_MAGIC, 16'h0000));
      offer(entry_word(16'haaaa, 16'h5555));
      offer(entry_word(16'h5555, 16'haaaa));
      offer(header_word(16'hffff, 16'hffff));
      queue_random_words(200);

      run_phase(16'd1, 16'd1, 16'd1, 1'b1, 150);

      // Largest legal geometry; a full table arrives while results are held back.
      run_phase(16'd65535, 16'd256, 16'd256, 1'b0, 0);
      queue_table(130, 1'b1, 3);
      hold_results = 1'b1;
      repeat (300) @(negedge clock);
      hold_results = 1'b0;
      queue_random_words(200);

      run_phase(16'd0, 16'd0, 16'd0, 1'b0, 60);
      // All-ones writes leave 511 tracks and sectors, so sector numbers wrap.
      run_phase(16'hffff, 16'hffff, 16'hffff, 1'b1, 150);
      run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
                16'($urandom_range(1, 8)), 1'b0, 120);
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 60);
      for (int k = 0; k < 5; k++)
         run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 256)),
                   16'($urandom_range(1, 256)), k[0], 80);

      wait_drained();
      repeat (50) @(posedge clock);
      mismatch_count += expected_reports.size();
      $display("Checked %0d result words for %0d table words, %0d tables, %0d geometries.",
               results_checked, words_accepted, tables_sent, settings_run);
      $display("Bad headers, end markers, full tables, odd geometry covered; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("[bad_sector_table_checker_core] OK");
      end else begin
         $display("[bad_sector_table_checker_core] ERROR");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Timed out with %0d words to send and %0d results outstanding.",
               table_words_to_send.size(), expected_reports.size());
      $display("[bad_sector_table_checker_core] ERROR");
      $finish;
   end

endmodule
